>>> sv/ppps_pkg.sv
// Shared types, constants and helper functions for the primer pair product scan.
package ppps_pkg;

   localparam int WIN_DEPTH = 32;
   localparam int OUT_LIMIT = 64;
   localparam int NRES_W    = 7;

   localparam logic [2:0] BASE_N = 3'd4;

   localparam logic [2:0] REG_FWD_BASES = 3'd0;
   localparam logic [2:0] REG_REV_BASES = 3'd1;
   localparam logic [2:0] REG_FWD_LEN   = 3'd2;
   localparam logic [2:0] REG_REV_LEN   = 3'd3;
   localparam logic [2:0] REG_PERF_LEN  = 3'd4;
   localparam logic [2:0] REG_GOOD_LEN  = 3'd5;
   localparam logic [2:0] REG_MAX_PROD  = 3'd6;
   localparam logic [2:0] REG_POS_OFF   = 3'd7;

   typedef struct packed {
      logic [63:0] fwd_bases;
      logic [63:0] rev_bases;
      logic [5:0]  fwd_len;
      logic [5:0]  rev_len;
      logic [5:0]  perf_len;
      logic [5:0]  good_len;
      logic [31:0] max_prod;
      logic [31:0] pos_off;
   } cfg_type;

   typedef struct packed {
      logic fwd_hit;
      logic rev_hit;
      logic tail_ok;
   } match_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FF_RD,
      ST_FF_WB,
      ST_DETECT,
      ST_RV_RD,
      ST_RV_EVAL,
      ST_RV_SCORE,
      ST_PR_RD,
      ST_PR_EVAL,
      ST_FLUSH
   } state_type;

   function automatic logic [5:0] good_span(input cfg_type c);
      return (c.good_len > c.perf_len) ? 6'(c.good_len - c.perf_len) : 6'd0;
   endfunction

   function automatic logic cfg_valid(input cfg_type c, input logic [6:0] max_primer);
      logic [5:0] mn;
      mn = (c.fwd_len < c.rev_len) ? c.fwd_len : c.rev_len;
      return (c.fwd_len != 6'd0) && ({1'b0, c.fwd_len} <= max_primer) &&
             (c.rev_len != 6'd0) && ({1'b0, c.rev_len} <= max_primer) &&
             (c.perf_len != 6'd0) && (c.perf_len <= mn) && (c.good_len <= mn);
   endfunction

endpackage

>>> sv/ppps_match.sv
// Window comparators: forward hit with score, reverse perfect hit, reverse tail score.
module ppps_match import ppps_pkg::*; #(
   parameter int POS_BITS = 32
) (
   input  cfg_type                         cfg,
   input  logic [WIN_DEPTH-1:0][2:0]       win,
   input  logic [POS_BITS-1:0]             age,
   output match_type                       res
);

   localparam int AW = POS_BITS + 2;

   always_comb begin
      logic [WIN_DEPTH-1:0] eqf, eqr, eqt, pmask, smask, tmask;
      logic [5:0]           gs;
      logic [6:0]           mf, mt;
      logic [POS_BITS-1:0]  len;
      logic signed [AW-1:0] tq;
      logic [1:0]           pb;
      int                   fidx, ridx;
      gs = good_span(cfg);
      for (int j = 0; j < WIN_DEPTH; j++) begin
         fidx = int'(cfg.fwd_len) - 1 - j;
         pb = cfg.fwd_bases[{fidx[4:0], 1'b0} +: 2];
         eqf[j] = (fidx >= 0) && (fidx < 32) && (win[j] != BASE_N) && (win[j][1:0] == pb);
         ridx = int'(cfg.rev_len) - int'(cfg.perf_len) + j;
         pb = ~cfg.rev_bases[{ridx[4:0], 1'b0} +: 2];
         eqr[j] = (ridx >= 0) && (ridx < 32) && (win[j] != BASE_N) && (win[j][1:0] == pb);
         tq = AW'(cfg.rev_len) - AW'(age) + AW'(j);
         pb = ~cfg.rev_bases[{tq[4:0], 1'b0} +: 2];
         eqt[j] = !tq[AW-1] && (tq < AW'(32)) && (win[j] != BASE_N) && (win[j][1:0] == pb);
         pmask[j] = (j < int'(cfg.perf_len));
         smask[j] = (j >= int'(cfg.perf_len)) && (j < int'(cfg.perf_len) + int'(gs));
         tmask[j] = (AW'(j) + AW'(1) + AW'(cfg.perf_len)) <= AW'(age);
      end
      mf = 7'($countones(eqf & smask));
      mt = 7'($countones(eqt & tmask));
      len = (age > POS_BITS'(cfg.perf_len)) ? age - POS_BITS'(cfg.perf_len) : '0;
      res.fwd_hit = ((eqf & pmask) == pmask) &&
                    (({2'b0, mf} + {1'b0, mf, 1'b0}) >= {2'b0, gs, 1'b0});
      res.rev_hit = ((eqr & pmask) == pmask);
      res.tail_ok = ((AW'(mt) + AW'({mt, 1'b0})) >= AW'({len, 1'b0}));
   end

endmodule

>>> sv/primer_pair_product_scan.sv
// Primer pair product scan: base window, pending hit memories and product sequencer.
// Steps: an item sweeps the pending forward hits (read, write-back), records new hits, then
// sweeps the pending reverse hits, scoring each that resolves and, if its tail score passes,
// pairing it with each pending forward hit; a bad configuration skips to the flush; stalls add wait.
// Throughput: one item at a time, set by the read-modify-write sweeps over the hit memories.
// Reset (synchronous, active high) restores the register defaults and empties window and stores.
module primer_pair_product_scan import ppps_pkg::*; #(
   parameter int MAX_PRIMER  = 32,
   parameter int FWD_PENDING = 8,
   parameter int REV_PENDING = 8,
   parameter int POS_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_base_code,
   input  logic        req_seq_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_product_start,
   output logic [31:0] rsp_product_end,
   output logic [4:0]  rsp_fwd_trim,
   output logic [4:0]  rsp_rev_trim,
   output logic        rsp_run_last,
   output logic        rsp_hits_dropped,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int FA = (FWD_PENDING > 1) ? $clog2(FWD_PENDING) : 1;
   localparam int FC = $clog2(FWD_PENDING + 1);
   localparam int RA = (REV_PENDING > 1) ? $clog2(REV_PENDING) : 1;
   localparam int RC = $clog2(REV_PENDING + 1);
   localparam int FW = 2 * POS_BITS + 5;
   localparam int SW = (POS_BITS > 32) ? POS_BITS + 1 : 33;

   cfg_type   cfg_ff;
   state_type state_ff, state_in;
   match_type mres;

   logic [WIN_DEPTH-1:0][2:0] win_ff;
   logic [POS_BITS-1:0]       cnt_ff, r_ff;
   logic [FC-1:0]             fcnt_ff, fi_ff, fw_ff;
   logic [RC-1:0]             rcnt_ff, ri_ff, rw_ff;
   logic [NRES_W-1:0]         nres_ff;
   logic                      ovf_ff, scan_ff, end_ff;

   logic [FW-1:0]       fmem [FWD_PENDING];
   logic [POS_BITS-1:0] rmem [REV_PENDING];
   logic [FW-1:0]       fmem_q_ff, fmem_wdata;
   logic [POS_BITS-1:0] rmem_q_ff, rmem_wdata;
   logic                fmem_re, fmem_we, rmem_re, rmem_we;
   logic [FA-1:0]       fmem_raddr, fmem_waddr;
   logic [RA-1:0]       rmem_raddr, rmem_waddr;

   logic        stg_vld_ff, rsp_valid_ff;
   logic [31:0] stg_start_ff, stg_end_ff, out_start_ff, out_end_ff;
   logic [4:0]  stg_ftrim_ff, stg_rtrim_ff, out_ftrim_ff, out_rtrim_ff;
   logic        stg_drop_ff, out_drop_ff, out_last_ff;

   logic                cfg_ok, accept, out_free, push, stall_here;
   logic [5:0]          gs, dlen;
   logic [POS_BITS-1:0] e_match, e_start, age_q, age_r, len_q, new_match, new_start;
   logic [4:0]          e_trim, new_trim;
   logic                f_keep, pair, emit, rv_wait, rv_drop, fwd_new, rev_new;
   logic [POS_BITS:0]   rend;

   assign cfg_ok = cfg_valid(cfg_ff, 7'(MAX_PRIMER));
   assign gs     = good_span(cfg_ff);
   assign dlen   = 6'(cfg_ff.fwd_len - cfg_ff.perf_len);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign {e_match, e_start, e_trim} = fmem_q_ff;
   assign age_q = cnt_ff - rmem_q_ff;
   assign age_r = cnt_ff - r_ff;
   assign len_q = (age_q > POS_BITS'(cfg_ff.perf_len)) ?
                  age_q - POS_BITS'(cfg_ff.perf_len) : '0;
   assign f_keep = SW'(cnt_ff - e_start) <= SW'(cfg_ff.max_prod);
   assign pair = (e_match <= r_ff) && f_keep;
   assign emit = pair && (nres_ff < NRES_W'(OUT_LIMIT));
   assign rv_wait = (age_q < POS_BITS'(cfg_ff.rev_len)) && !end_ff;
   assign rv_drop = len_q < POS_BITS'(gs);
   assign rend = (POS_BITS + 1)'(r_ff) + (POS_BITS + 1)'(cfg_ff.rev_len);

   assign new_match = cnt_ff - POS_BITS'(cfg_ff.perf_len);
   assign new_start = (new_match >= POS_BITS'(dlen)) ? new_match - POS_BITS'(dlen) : '0;
   assign new_trim  = (new_match >= POS_BITS'(dlen)) ? 5'd0 : 5'(POS_BITS'(dlen) - new_match);
   assign fwd_new = scan_ff && mres.fwd_hit &&
                    ((POS_BITS + 1)'(cnt_ff) >= (POS_BITS + 1)'(cfg_ff.perf_len) +
                                               (POS_BITS + 1)'(gs));
   assign rev_new = scan_ff && mres.rev_hit &&
                    ((POS_BITS + 1)'(cnt_ff) >= (POS_BITS + 1)'(cfg_ff.perf_len));

   ppps_match #(.POS_BITS(POS_BITS)) u_match (
      .cfg (cfg_ff),
      .win (win_ff),
      .age (age_r),
      .res (mres)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (accept) state_in = cfg_ok ? ST_FF_RD : ST_FLUSH;
         ST_FF_RD:    state_in = (fi_ff < fcnt_ff) ? ST_FF_WB : ST_DETECT;
         ST_FF_WB:    state_in = ST_FF_RD;
         ST_DETECT:   state_in = ST_RV_RD;
         ST_RV_RD:    state_in = (ri_ff < rcnt_ff) ? ST_RV_EVAL : ST_FLUSH;
         ST_RV_EVAL:  state_in = (rv_wait || rv_drop) ? ST_RV_RD : ST_RV_SCORE;
         ST_RV_SCORE: state_in = mres.tail_ok ? ST_PR_RD : ST_RV_RD;
         ST_PR_RD:    state_in = (fi_ff < fcnt_ff) ? ST_PR_EVAL : ST_RV_RD;
         ST_PR_EVAL:  if (!stall_here) state_in = ST_PR_RD;
         ST_FLUSH:    if (!stall_here) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      fmem_re    = 1'b0;
      fmem_raddr = fi_ff[FA-1:0];
      fmem_we    = 1'b0;
      fmem_waddr = fw_ff[FA-1:0];
      fmem_wdata = fmem_q_ff;
      rmem_re    = 1'b0;
      rmem_raddr = ri_ff[RA-1:0];
      rmem_we    = 1'b0;
      rmem_waddr = rw_ff[RA-1:0];
      rmem_wdata = rmem_q_ff;
      stall_here = 1'b0;
      push       = 1'b0;
      unique case (state_ff)
         ST_FF_RD: fmem_re = (fi_ff < fcnt_ff);
         ST_PR_RD: fmem_re = (fi_ff < fcnt_ff);
         ST_RV_RD: rmem_re = (ri_ff < rcnt_ff);
         ST_FF_WB: fmem_we = f_keep;
         ST_RV_EVAL: rmem_we = rv_wait;
         ST_DETECT: begin
            fmem_we    = fwd_new && (fcnt_ff < FC'(FWD_PENDING));
            fmem_waddr = fcnt_ff[FA-1:0];
            fmem_wdata = {new_match, new_start, new_trim};
            rmem_we    = rev_new && (rcnt_ff < RC'(REV_PENDING));
            rmem_waddr = rcnt_ff[RA-1:0];
            rmem_wdata = new_match;
         end
         ST_PR_EVAL: begin
            stall_here = emit && stg_vld_ff && !out_free;
            push       = emit && stg_vld_ff && out_free;
         end
         ST_FLUSH: begin
            stall_here = stg_vld_ff && !out_free;
            push       = stg_vld_ff && out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fmem_re) fmem_q_ff <= fmem[fmem_raddr];
      if (fmem_we) fmem[fmem_waddr] <= fmem_wdata;
      if (rmem_re) rmem_q_ff <= rmem[rmem_raddr];
      if (rmem_we) rmem[rmem_waddr] <= rmem_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fwd_bases <= '0;
         cfg_ff.rev_bases <= '0;
         cfg_ff.fwd_len   <= 6'd20;
         cfg_ff.rev_len   <= 6'd20;
         cfg_ff.perf_len  <= 6'd15;
         cfg_ff.good_len  <= 6'd15;
         cfg_ff.max_prod  <= 32'd4000;
         cfg_ff.pos_off   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FWD_BASES: cfg_ff.fwd_bases <= csr_data;
            REG_REV_BASES: cfg_ff.rev_bases <= csr_data;
            REG_FWD_LEN:   cfg_ff.fwd_len   <= csr_data[5:0];
            REG_REV_LEN:   cfg_ff.rev_len   <= csr_data[5:0];
            REG_PERF_LEN:  cfg_ff.perf_len  <= csr_data[5:0];
            REG_GOOD_LEN:  cfg_ff.good_len  <= csr_data[5:0];
            REG_MAX_PROD:  cfg_ff.max_prod  <= csr_data[31:0];
            REG_POS_OFF:   cfg_ff.pos_off   <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= {WIN_DEPTH{BASE_N}};
         cnt_ff       <= '0;
         fcnt_ff      <= '0;
         rcnt_ff      <= '0;
         ovf_ff       <= 1'b0;
         stg_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (push) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               scan_ff <= (cnt_ff != '1);
               if (cnt_ff != '1) begin
                  for (int j = WIN_DEPTH - 1; j > 0; j--) win_ff[j] <= win_ff[j-1];
                  win_ff[0] <= (req_base_code > BASE_N) ? BASE_N : req_base_code;
                  cnt_ff    <= cnt_ff + POS_BITS'(1);
               end
               end_ff  <= req_seq_end;
               nres_ff <= '0;
               fi_ff   <= '0;
               fw_ff   <= '0;
            end
            ST_FF_RD: if (!(fi_ff < fcnt_ff)) fcnt_ff <= fw_ff;
            ST_FF_WB: begin
               fi_ff <= fi_ff + FC'(1);
               if (f_keep) fw_ff <= fw_ff + FC'(1);
            end
            ST_DETECT: begin
               ri_ff <= '0;
               rw_ff <= '0;
               if (fwd_new && (fcnt_ff < FC'(FWD_PENDING))) fcnt_ff <= fcnt_ff + FC'(1);
               if (rev_new && (rcnt_ff < RC'(REV_PENDING))) rcnt_ff <= rcnt_ff + RC'(1);
               if ((fwd_new && !(fcnt_ff < FC'(FWD_PENDING))) ||
                   (rev_new && !(rcnt_ff < RC'(REV_PENDING))))
                  ovf_ff <= 1'b1;
            end
            ST_RV_RD: if (!(ri_ff < rcnt_ff)) rcnt_ff <= rw_ff;
            ST_RV_EVAL: begin
               r_ff <= rmem_q_ff;
               if (rv_wait) rw_ff <= rw_ff + RC'(1);
               if (rv_wait || rv_drop) ri_ff <= ri_ff + RC'(1);
            end
            ST_RV_SCORE: begin
               if (mres.tail_ok) fi_ff <= '0;
               else ri_ff <= ri_ff + RC'(1);
            end
            ST_PR_RD: if (!(fi_ff < fcnt_ff)) ri_ff <= ri_ff + RC'(1);
            ST_PR_EVAL: if (!stall_here) begin
               fi_ff <= fi_ff + FC'(1);
               if (emit) begin
                  stg_vld_ff   <= 1'b1;
                  stg_start_ff <= 32'(SW'(e_start) + SW'(cfg_ff.pos_off));
                  stg_end_ff   <= 32'(SW'(cnt_ff) + SW'(cfg_ff.pos_off));
                  stg_ftrim_ff <= e_trim;
                  stg_rtrim_ff <= (rend > (POS_BITS + 1)'(cnt_ff)) ?
                                  5'(rend - (POS_BITS + 1)'(cnt_ff)) : 5'd0;
                  stg_drop_ff  <= ovf_ff;
                  ovf_ff       <= 1'b0;
                  nres_ff      <= nres_ff + NRES_W'(1);
               end else if (pair) begin
                  ovf_ff <= 1'b1;
               end
            end
            ST_FLUSH: if (!stall_here) begin
               stg_vld_ff <= 1'b0;
               if (end_ff) begin
                  win_ff  <= {WIN_DEPTH{BASE_N}};
                  cnt_ff  <= '0;
                  fcnt_ff <= '0;
                  rcnt_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_start_ff <= stg_start_ff;
         out_end_ff   <= stg_end_ff;
         out_ftrim_ff <= stg_ftrim_ff;
         out_rtrim_ff <= stg_rtrim_ff;
         out_drop_ff  <= stg_drop_ff;
         out_last_ff  <= (state_ff == ST_FLUSH);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_start = out_start_ff;
   assign rsp_product_end   = out_end_ff;
   assign rsp_fwd_trim      = out_ftrim_ff;
   assign rsp_rev_trim      = out_rtrim_ff;
   assign rsp_run_last      = out_last_ff;
   assign rsp_hits_dropped  = out_drop_ff;

endmodule

>>> tb/primer_pair_product_scan_tb.sv
// Self-checking testbench for the primer pair product scan: predicts products per base transfer.
`timescale 1ns / 1ps
module primer_pair_product_scan_tb;
   import ppps_pkg::*;

   localparam int FWD_PEND = 8;
   localparam int REV_PEND = 8;
   localparam longint LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [2:0] base_code;
      logic       seq_end;
   } base_item_t;

   typedef struct packed {
      logic [31:0] product_start;
      logic [31:0] product_end;
      logic [4:0]  fwd_trim;
      logic [4:0]  rev_trim;
      logic        run_last;
      logic        hits_dropped;
   } product_t;

   typedef struct {
      longint unsigned match_pos;
      longint unsigned start_pos;
      int unsigned     trim;
   } fwd_hit_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_base_code;
   logic        req_seq_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_product_start;
   logic [31:0] rsp_product_end;
   logic [4:0]  rsp_fwd_trim;
   logic [4:0]  rsp_rev_trim;
   logic        rsp_run_last;
   logic        rsp_hits_dropped;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   primer_pair_product_scan dut (.*);

   base_item_t  pending_bases[$];
   product_t    expected_products[$];
   int          errors;
   longint      cycle_count;
   bit          idle_enabled;
   bit          hold_rsp;
   int          send_gap;
   int          recv_gap;

   // predictor state
   logic [63:0] p_fwd_bases, p_rev_bases;
   int unsigned p_fwd_len, p_rev_len, p_perf_len, p_good_len;
   logic [31:0] p_max_prod, p_pos_off;
   logic [2:0]  win[32];
   longint unsigned seen_count;
   fwd_hit_t    fwd_hits[$];
   longint unsigned rev_hits[$];
   bit          dropped;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [2:0] win_at(longint k);
      if (k < 0 || k >= 32) return BASE_N;
      return win[k];
   endfunction

   function automatic logic [2:0] fwd_base(longint i);
      if (i < 0 || i >= p_fwd_len || i >= 32) return 3'd5;
      return {1'b0, p_fwd_bases[2*i +: 2]};
   endfunction

   function automatic logic [2:0] rc_base(longint i);
      longint j;
      j = longint'(p_rev_len) - 1 - i;
      if (i < 0 || j < 0 || j >= 32) return 3'd5;
      return {1'b0, 2'd3 - p_rev_bases[2*j +: 2]};
   endfunction

   function automatic void clear_sequence();
      foreach (win[k]) win[k] = BASE_N;
      seen_count = 0;
      fwd_hits.delete();
      rev_hits.delete();
   endfunction

   function automatic void predictor_reset();
      p_fwd_bases = 0;
      p_rev_bases = 0;
      p_fwd_len = 20;
      p_rev_len = 20;
      p_perf_len = 15;
      p_good_len = 15;
      p_max_prod = 4000;
      p_pos_off = 0;
      dropped = 0;
      clear_sequence();
   endfunction

   function automatic void predictor_config(logic [2:0] idx, logic [63:0] val);
      case (idx)
         REG_FWD_BASES: p_fwd_bases = val;
         REG_REV_BASES: p_rev_bases = val;
         REG_FWD_LEN:   p_fwd_len = val[5:0];
         REG_REV_LEN:   p_rev_len = val[5:0];
         REG_PERF_LEN:  p_perf_len = val[5:0];
         REG_GOOD_LEN:  p_good_len = val[5:0];
         REG_MAX_PROD:  p_max_prod = val[31:0];
         default:       p_pos_off = val[31:0];
      endcase
   endfunction

   function automatic bit config_ok();
      int unsigned mn;
      mn = (p_fwd_len < p_rev_len) ? p_fwd_len : p_rev_len;
      if (p_fwd_len < 1 || p_fwd_len > 32) return 0;
      if (p_rev_len < 1 || p_rev_len > 32) return 0;
      if (p_perf_len < 1 || p_perf_len > mn || p_good_len > mn) return 0;
      return 1;
   endfunction

   function automatic void predict_products(base_item_t it);
      logic [2:0] b;
      bit scan, hit;
      longint unsigned n, r, rend;
      longint pl, gs, d, score, age, len;
      int nres, first;
      fwd_hit_t e, kept[$];
      longint unsigned rkeep[$];
      product_t p;
      b = (it.base_code > 4) ? BASE_N : it.base_code;
      scan = 0;
      nres = 0;
      first = expected_products.size();
      if (seen_count < 64'hFFFF_FFFF) begin
         for (int k = 31; k > 0; k--) win[k] = win[k-1];
         win[0] = b;
         seen_count++;
         scan = 1;
      end
      n = seen_count;
      if (config_ok()) begin
         pl = p_perf_len;
         gs = (p_good_len > p_perf_len) ? p_good_len - p_perf_len : 0;
         foreach (fwd_hits[i])
            if (n - fwd_hits[i].start_pos <= p_max_prod) kept.push_back(fwd_hits[i]);
         fwd_hits = kept;
         if (scan && n >= pl + gs) begin
            hit = 1;
            score = 0;
            d = longint'(p_fwd_len) - pl;
            for (int k = 0; k < pl; k++)
               if (win_at(k) != fwd_base(longint'(p_fwd_len) - 1 - k)) hit = 0;
            for (int k = 0; hit && k < gs; k++)
               score += (win_at(pl + k) == fwd_base(d - 1 - k)) ? 1 : -2;
            if (hit && score >= 0) begin
               if (fwd_hits.size() < FWD_PEND) begin
                  e.match_pos = n - pl;
                  if (e.match_pos >= d) begin
                     e.start_pos = e.match_pos - d;
                     e.trim = 0;
                  end else begin
                     e.start_pos = 0;
                     e.trim = d - e.match_pos;
                  end
                  fwd_hits.push_back(e);
               end else dropped = 1;
            end
         end
         if (scan && n >= pl) begin
            hit = 1;
            for (int k = 0; k < pl; k++)
               if (win_at(pl - 1 - k) != rc_base(k)) hit = 0;
            if (hit) begin
               if (rev_hits.size() < REV_PEND) rev_hits.push_back(n - pl);
               else dropped = 1;
            end
         end
         foreach (rev_hits[i]) begin
            r = rev_hits[i];
            age = n - r;
            if (age < p_rev_len && !it.seq_end) begin
               rkeep.push_back(r);
               continue;
            end
            len = age - pl;
            if (len < 0) len = 0;
            if (len < gs) continue;
            score = 0;
            for (int k = 0; k < len; k++)
               score += (win_at(age - 1 - pl - k) == rc_base(pl + k)) ? 1 : -2;
            if (score < 0) continue;
            foreach (fwd_hits[f]) begin
               rend = r + p_rev_len;
               if (fwd_hits[f].match_pos > r || n - fwd_hits[f].start_pos > p_max_prod)
                  continue;
               if (nres >= OUT_LIMIT) begin
                  dropped = 1;
                  continue;
               end
               p.product_start = fwd_hits[f].start_pos + p_pos_off;
               p.product_end = n + p_pos_off;
               p.fwd_trim = fwd_hits[f].trim;
               p.rev_trim = (rend > n) ? rend - n : 0;
               p.run_last = 0;
               p.hits_dropped = dropped;
               dropped = 0;
               expected_products.push_back(p);
               nres++;
            end
         end
         rev_hits = rkeep;
      end
      if (nres > 0) expected_products[first + nres - 1].run_last = 1;
      if (it.seq_end) clear_sequence();
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         predict_products({req_base_code, req_seq_end});
         if (idle_enabled && $urandom_range(0, 5) == 0) begin
            req_valid <= 0;
            send_gap <= $urandom_range(0, 13);
         end else if (pending_bases.size() > 0) begin
            {req_base_code, req_seq_end} <= pending_bases.pop_front();
         end else req_valid <= 0;
      end else if (!req_valid) begin
         if (send_gap > 0) send_gap <= send_gap - 1;
         else if (pending_bases.size() > 0) begin
            {req_base_code, req_seq_end} <= pending_bases.pop_front();
            req_valid <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      product_t got, want;
      if (reset) begin
         rsp_stall <= 0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_product_start, rsp_product_end, rsp_fwd_trim, rsp_rev_trim,
                   rsp_run_last, rsp_hits_dropped};
            if (expected_products.size() == 0) begin
               $display("%0t unexpected product: actual %h", $time, got);
               errors++;
            end else begin
               want = expected_products.pop_front();
               if (got.product_start !== want.product_start)
                  $display("%0t product_start: expected %h actual %h", $time,
                           want.product_start, got.product_start);
               if (got.product_end !== want.product_end)
                  $display("%0t product_end: expected %h actual %h", $time,
                           want.product_end, got.product_end);
               if (got.fwd_trim !== want.fwd_trim)
                  $display("%0t fwd_trim: expected %0d actual %0d", $time,
                           want.fwd_trim, got.fwd_trim);
               if (got.rev_trim !== want.rev_trim)
                  $display("%0t rev_trim: expected %0d actual %0d", $time,
                           want.rev_trim, got.rev_trim);
               if (got.run_last !== want.run_last)
                  $display("%0t run_last: expected %0b actual %0b", $time,
                           want.run_last, got.run_last);
               if (got.hits_dropped !== want.hits_dropped)
                  $display("%0t hits_dropped: expected %0b actual %0b", $time,
                           want.hits_dropped, got.hits_dropped);
               if (got !== want) errors++;
            end
         end
         if (hold_rsp) rsp_stall <= 1;
         else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(0, 13);
            rsp_stall <= 1;
         end else rsp_stall <= 0;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      predictor_config(idx, val);
      csr_write <= 0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_bases.size() > 0 || req_valid || expected_products.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [2:0] primer_base(logic [63:0] bases, int i);
      return {1'b0, bases[2*i +: 2]};
   endfunction

   // whole primer, filler, reverse-complement site
   task automatic queue_amplicon(int gap, bit close_seq);
      int lr;
      lr = p_rev_len;
      for (int i = 0; i < p_fwd_len; i++)
         pending_bases.push_back({primer_base(p_fwd_bases, i), 1'b0});
      for (int i = 0; i < gap; i++)
         pending_bases.push_back({3'($urandom_range(0, 4)), 1'b0});
      for (int i = 0; i < lr; i++)
         pending_bases.push_back({3'd3 - primer_base(p_rev_bases, lr - 1 - i), 1'b0});
      if (close_seq) pending_bases.push_back({3'($urandom_range(0, 7)), 1'b1});
   endtask

   task automatic queue_noise(int count);
      for (int i = 0; i < count; i++)
         pending_bases.push_back({3'($urandom_range(0, 7)), 1'($urandom_range(0, 15) == 0)});
   endtask

   task automatic set_primers(int fl, int rl, int perf, int good, logic [31:0] mp,
                              logic [31:0] off);
      write_reg(REG_FWD_BASES, {$urandom, $urandom});
      write_reg(REG_REV_BASES, {$urandom, $urandom});
      write_reg(REG_FWD_LEN, fl);
      write_reg(REG_REV_LEN, rl);
      write_reg(REG_PERF_LEN, perf);
      write_reg(REG_GOOD_LEN, good);
      write_reg(REG_MAX_PROD, mp);
      write_reg(REG_POS_OFF, off);
   endtask

   initial begin
      int fl, rl, perf, good;
      errors = 0;
      cycle_count = 0;
      idle_enabled = 0;
      hold_rsp = 0;
      reset = 1;
      req_valid = 0;
      req_base_code = 0;
      req_seq_end = 0;
      rsp_stall = 0;
      csr_write = 0;
      csr_index = REG_FWD_BASES;
      csr_data = 0;
      predictor_reset();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: short primers, truncated tail at sequence end, base codes above N
      set_primers(4, 4, 2, 4, 64, 32'hFFFF_FFF0);
      pending_bases.push_back({3'd7, 1'b0});
      pending_bases.push_back({3'd4, 1'b0});
      queue_amplicon(1, 0);
      pending_bases.push_back({3'd5, 1'b1});
      for (int i = 0; i < 4; i++)
         pending_bases.push_back({primer_base(p_fwd_bases, i), 1'b0});
      pending_bases.push_back({3'd3 - primer_base(p_rev_bases, 3), 1'b1});
      wait_drained();
      // bad configuration and good below perfect
      set_primers(0, 4, 2, 1, 32'hFFFF_FFFF, 0);
      queue_amplicon(2, 1);
      wait_drained();
      write_reg(REG_FWD_LEN, 33);
      queue_amplicon(2, 1);
      wait_drained();
      write_reg(REG_FWD_LEN, 32);
      write_reg(REG_REV_LEN, 32);
      write_reg(REG_PERF_LEN, 32);
      write_reg(REG_GOOD_LEN, 32);
      write_reg(REG_MAX_PROD, 1);
      queue_amplicon(0, 1);
      wait_drained();

      // random phases with idling
      idle_enabled = 1;
      for (int ph = 0; ph < 7; ph++) begin
         fl = $urandom_range(1, 6);
         rl = $urandom_range(1, 6);
         perf = $urandom_range(1, (fl < rl) ? fl : rl);
         good = $urandom_range(0, (fl < rl) ? fl : rl);
         set_primers(fl, rl, perf, good,
                     (ph % 3 == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 40), $urandom);
         if (ph == 4) hold_rsp = 1;
         for (int j = 0; j < 6; j++) begin
            if ($urandom_range(0, 3) != 0) queue_amplicon($urandom_range(0, 3), 0);
            else queue_noise($urandom_range(1, 6));
         end
         pending_bases.push_back({3'($urandom_range(0, 4)), 1'b1});
         if (ph == 4) begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         if (ph >= 5) idle_enabled = 0;
         wait_drained();
      end

      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
